@@ rtl/edf_tick_scheduler_defines.svh @@
// Assertion macros for the EDF tick scheduler.
// Used by the top level only; no other dependencies.
`ifndef EDF_TICK_SCHEDULER_DEFINES_SVH
`define EDF_TICK_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
`define EDF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define EDF_ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);
`else
`define EDF_ASSERT(lbl, clk, rstn, prop, msg)
`define EDF_ASSERT_NEVER(lbl, clk, rstn, prop, msg)
`endif
`endif

@@ rtl/edf_pkg.sv @@
// Shared types and constants of the EDF tick scheduler.
// No dependencies.
package edf_pkg;
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [23:0] UTIL_MAX = 24'hFFFFFF;
  localparam logic [23:0] UTIL_ONE = 24'h010000;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] arrival_time;
    logic [15:0] exec_time;
    logic [15:0] deadline;
  } edf_cmd_t;

  typedef struct packed {
    logic [31:0] now_time;
    logic [5:0]  task_id;
    logic        task_finished;
    logic        all_done;
    logic [23:0] utilization;
    logic        feasible;
    logic        table_full;
  } edf_res_t;
endpackage

@@ rtl/edf_tick_scheduler.sv @@
// Channel   Dir  Word fields (lowest bit first)
// s_axis    in   tuser: func[1:0]; tdata: arrival_time[15:0] exec_time[31:16] deadline[47:32]
// m_axis    out  now_time task_id task_finished all_done utilization feasible table_full
// A load with a non-zero deadline passes through the bit-serial Q8.16 divider; a refused
// load or one with a zero deadline goes straight to the result. A tick scans the loaded
// tasks (one table read per cycle in the deadline scan), a clear goes straight to the result;
// each ends in the output handshake. Reset empties the table; the task stores need no clearing.
// The input queue holds two words while a result waits on the output.
// Top level of the EDF tick scheduler; depends on edf_pkg, edf_cmd_fifo, edf_core.
`include "edf_tick_scheduler_defines.svh"
module edf_tick_scheduler #(
  parameter int MAX_TASKS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,  // func
  input  logic [47:0] s_axis_tdata,  // arrival_time, exec_time, deadline
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata   // now_time, task_id, task_finished, all_done,
                                     // utilization, feasible, table_full
);
  import edf_pkg::*;

  edf_cmd_t cmd_in, cmd_q;
  edf_res_t res;
  logic full, empty, core_ready;

  assign cmd_in.func         = s_axis_tuser;
  assign cmd_in.arrival_time = s_axis_tdata[15:0];
  assign cmd_in.exec_time    = s_axis_tdata[31:16];
  assign cmd_in.deadline     = s_axis_tdata[47:32];
  assign s_axis_tready = !full;

  edf_cmd_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(s_axis_tvalid), .wdata_i(cmd_in), .full_o(full),
    .pop_i(core_ready), .rdata_o(cmd_q), .empty_o(empty)
  );

  edf_core #(.MAX_TASKS(MAX_TASKS)) u_core (
    .clk_i, .rst_ni,
    .cmd_valid_i(!empty), .cmd_i(cmd_q), .cmd_ready_o(core_ready),
    .res_valid_o(m_axis_tvalid), .res_o(res), .res_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {6'd0, res.table_full, res.feasible, res.utilization, res.all_done,
                         res.task_finished, res.task_id, res.now_time};

  `EDF_ASSERT_NEVER(a_id_range, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tdata[37:32] > 6'(MAX_TASKS), "task id out of range")
  `EDF_ASSERT_NEVER(a_fin_idle, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tdata[38] && m_axis_tdata[37:32] == 6'd0, "idle tick finished")
  `EDF_ASSERT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
    "result changed while stalled")
endmodule

@@ rtl/edf_cmd_fifo.sv @@
// Two-entry word queue between the front and back parts of the scheduler.
// Depends on edf_pkg.
module edf_cmd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  edf_pkg::edf_cmd_t wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output edf_pkg::edf_cmd_t rdata_o,
  output logic             empty_o
);
  import edf_pkg::*;

  edf_cmd_t    mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wp_q <= ~wp_q;
      if (pop_i && !empty_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i && !full_o} - {1'b0, pop_i && !empty_o};
    end
  end
endmodule

@@ rtl/edf_core.sv @@
// Back part of the scheduler: task table, sequential divider, deadline scan.
// Depends on edf_pkg.
module edf_core #(
  parameter int MAX_TASKS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  edf_pkg::edf_cmd_t cmd_i,
  output logic              cmd_ready_o,
  output logic              res_valid_o,
  output edf_pkg::edf_res_t res_o,
  input  logic              res_ready_i
);
  import edf_pkg::*;

  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_DEC2 = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  st_q;
  logic [15:0] arr_mem [MAX_TASKS];
  logic [15:0] dl_mem  [MAX_TASKS];
  logic [15:0] rem_mem [MAX_TASKS];
  logic [CW-1:0] task_cnt_q, fin_cnt_q;
  logic [31:0] time_q, now_q;
  logic [23:0] util_q;

  logic [31:0] quo_q;
  logic [16:0] prem_q;
  logic [15:0] div_q;
  logic [5:0]  bit_q;

  logic [CW-1:0] idx_q;
  logic          found_q;
  logic [IW-1:0] best_q;
  logic [15:0]   best_dl_q;
  logic [15:0]   rd_arr_q, rd_dl_q, rd_rem_q;
  logic          rd_ok_q;
  logic [5:0]    id_q;
  logic          fin_q, full_q;

  logic [16:0] trial;
  logic [16:0] shifted;
  logic [24:0] usum;
  logic        cand;

  assign shifted = {prem_q[15:0], quo_q[31]};
  assign trial   = shifted - {1'b0, div_q};
  assign usum    = {1'b0, util_q} + ((|quo_q[31:24]) ? {1'b0, UTIL_MAX} : {1'b0, quo_q[23:0]});
  assign cand    = rd_ok_q && ({16'd0, rd_arr_q} <= time_q) && (rd_rem_q != 16'd0) &&
                   (!found_q || rd_dl_q < best_dl_q);
  assign cmd_ready_o = st_q == S_IDLE;
  assign res_valid_o = st_q == S_OUT;

  always_comb begin
    res_o.now_time      = now_q;
    res_o.task_id       = id_q;
    res_o.task_finished = fin_q;
    res_o.all_done      = fin_cnt_q == task_cnt_q;
    res_o.utilization   = util_q;
    res_o.feasible      = util_q <= UTIL_ONE;
    res_o.table_full    = full_q;
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && cmd_valid_i && cmd_i.func == FUNC_LOAD &&
        task_cnt_q < CW'(MAX_TASKS)) begin
      arr_mem[task_cnt_q[IW-1:0]] <= cmd_i.arrival_time;
      dl_mem[task_cnt_q[IW-1:0]]  <= cmd_i.deadline;
      rem_mem[task_cnt_q[IW-1:0]] <= cmd_i.exec_time;
    end else if (st_q == S_DEC2) begin
      rem_mem[best_q] <= rd_rem_q - 16'd1;
    end
    rd_arr_q <= arr_mem[idx_q[IW-1:0]];
    rd_dl_q  <= dl_mem[idx_q[IW-1:0]];
    rd_rem_q <= rem_mem[(st_q == S_DEC) ? best_q : idx_q[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      task_cnt_q <= '0;
      fin_cnt_q <= '0;
      time_q <= '0;
      util_q <= '0;
      now_q <= '0;
      id_q <= '0;
      fin_q <= 1'b0;
      full_q <= 1'b0;
      quo_q <= '0;
      prem_q <= '0;
      div_q <= '0;
      bit_q <= '0;
      idx_q <= '0;
      found_q <= 1'b0;
      best_q <= '0;
      best_dl_q <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      case (st_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            id_q <= '0;
            fin_q <= 1'b0;
            full_q <= 1'b0;
            now_q <= time_q;
            st_q <= S_OUT;
            case (cmd_i.func)
              FUNC_LOAD: begin
                if (task_cnt_q >= CW'(MAX_TASKS)) begin
                  full_q <= 1'b1;
                end else begin
                  task_cnt_q <= task_cnt_q + CW'(1);
                  if (cmd_i.exec_time == 16'd0) fin_cnt_q <= fin_cnt_q + CW'(1);
                  if (cmd_i.deadline == 16'd0) begin
                    util_q <= UTIL_MAX;
                  end else begin
                    quo_q <= {cmd_i.exec_time, 16'd0};
                    prem_q <= '0;
                    div_q <= cmd_i.deadline;
                    bit_q <= '0;
                    st_q <= S_DIV;
                  end
                end
              end
              FUNC_TICK: begin
                idx_q <= '0;
                found_q <= 1'b0;
                rd_ok_q <= 1'b0;
                st_q <= S_SCAN;
              end
              FUNC_CLEAR: begin
                task_cnt_q <= '0;
                fin_cnt_q <= '0;
                time_q <= '0;
                util_q <= '0;
                now_q <= '0;
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (!trial[16]) begin
            prem_q <= trial;
            quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            prem_q <= shifted;
            quo_q <= {quo_q[30:0], 1'b0};
          end
          bit_q <= bit_q + 6'd1;
          if (bit_q == 6'd32) begin
            quo_q <= quo_q;
            util_q <= usum[24] ? UTIL_MAX : usum[23:0];
            st_q <= S_OUT;
          end
        end
        S_SCAN: begin
          if (cand) begin
            found_q <= 1'b1;
            best_q <= IW'(idx_q - CW'(1));
            best_dl_q <= rd_dl_q;
          end
          if (idx_q < task_cnt_q) begin
            idx_q <= idx_q + CW'(1);
            rd_ok_q <= 1'b1;
          end else begin
            rd_ok_q <= 1'b0;
            if (cand || found_q) begin
              st_q <= S_DEC;
            end else begin
              time_q <= time_q + 32'd1;
              st_q <= S_OUT;
            end
          end
        end
        S_DEC: st_q <= S_DEC2;
        S_DEC2: begin
          id_q <= 6'(best_q) + 6'd1;
          if (rd_rem_q == 16'd1) begin
            fin_q <= 1'b1;
            fin_cnt_q <= fin_cnt_q + CW'(1);
          end
          time_q <= time_q + 32'd1;
          st_q <= S_OUT;
        end
        S_OUT: if (res_ready_i) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule
